[rtl/ipv4_multibit_trie_route_table_top_assert.svh]
// Assertion macros used by the route table datapath.
`ifndef IPV4_MULTIBIT_TRIE_ROUTE_TABLE_TOP_ASSERT_SVH
`define IPV4_MULTIBIT_TRIE_ROUTE_TABLE_TOP_ASSERT_SVH

// The consequent holds in the same cycle as the antecedent.
`define RTRIE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define RTRIE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/rtrie_pkg.sv]
// ----------------------------------------------------------------------------
// Route table package
// Types, constants and codes shared by the route table controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package rtrie_pkg;

   localparam int DEF_NUM_BLOCKS   = 1024;
   localparam int DEF_STATUS_WIDTH = 32;
   localparam int ROOT_STRIDE      = 16;
   localparam int LEVEL_STRIDE     = 8;
   localparam int ROOT_SIZE        = 1 << ROOT_STRIDE;
   localparam int LEVEL_SIZE       = 1 << LEVEL_STRIDE;
   localparam int ADDR_WIDTH       = 32;
   localparam int LEN_WIDTH        = 6;
   localparam int FIELD_WIDTH      = 32;
   localparam int MAX_PREFIX       = 32;

   localparam logic OPERATION_LOOKUP = 1'b0;
   localparam logic OPERATION_SET    = 1'b1;

   typedef struct packed {
      logic                   operation;
      logic [ADDR_WIDTH-1:0]  address;
      logic [LEN_WIDTH-1:0]   prefix_length;
      logic [FIELD_WIDTH-1:0] status_value;
   } req_type;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] status;
      logic                   failed;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE, ST_DISPATCH, ST_RINIT, ST_LK_ROOT, ST_LK_L1, ST_LK_L2,
      ST_RS_RD, ST_RS_CHK, ST_RS_WR, ST_F_RD, ST_F_CHK, ST_F_SELF,
      ST_S1_CHK, ST_S1_GO, ST_S2_CHK, ST_S2_GO, ST_ALLOC, ST_ALLOC_GOT,
      ST_INIT, ST_LINK, ST_LS_RD, ST_LS_CHK, ST_DONE
   } state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_CAPTURE, OP_LOOKUP_GO, OP_CLEAR_ALL, OP_RINIT_GO, OP_RINIT,
      OP_RS_GO, OP_S1_RD, OP_LK_ROOT, OP_LK_L1, OP_LK_L2, OP_RS_RD, OP_RS_CHK,
      OP_RS_WR, OP_F_RD, OP_F_CHK, OP_F_SELF, OP_S1_CHK, OP_S1_GO, OP_S2_CHK,
      OP_S2_GO, OP_ALLOC, OP_ALLOC_GOT, OP_INIT, OP_LINK, OP_LS_RD, OP_LS_CHK,
      OP_EMIT
   } dp_op_type;

   typedef struct packed {
      logic is_set;
      logic len_zero;
      logic len_le16;
      logic len_le24;
      logic root_present;
      logic root_has;
      logic lvl_has;
      logic last;
      logic j_last;
      logic pool_empty;
      logic tier;
      logic rsp_free;
   } dp_status_type;

endpackage

[rtl/rtrie_ram.sv]
// ----------------------------------------------------------------------------
// Route table RAM
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module rtrie_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 256,
   parameter int ADDR_W = 8
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic              re,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/rtrie_ctrl.sv]
// ----------------------------------------------------------------------------
// Route table controller
// State machine that sequences lookups, range writes, block allocation and
// subtree release through the datapath.
// ----------------------------------------------------------------------------
module rtrie_ctrl
   import rtrie_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  dp_status_type status,
   output dp_op_type     cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            if (!status.is_set) begin
               state_in = status.root_present ? ST_LK_ROOT : ST_DONE;
            end else if (status.len_zero) begin
               state_in = ST_DONE;
            end else if (!status.root_present) begin
               state_in = ST_RINIT;
            end else if (status.len_le16) begin
               state_in = ST_RS_RD;
            end else begin
               state_in = ST_S1_CHK;
            end
         end
         ST_RINIT: begin
            if (status.last) state_in = ST_DISPATCH;
         end
         ST_LK_ROOT:   state_in = status.root_has ? ST_LK_L1 : ST_DONE;
         ST_LK_L1:     state_in = status.lvl_has ? ST_LK_L2 : ST_DONE;
         ST_LK_L2:     state_in = ST_DONE;
         ST_RS_RD:     state_in = ST_RS_CHK;
         ST_RS_CHK:    state_in = status.root_has ? ST_F_RD : ST_RS_WR;
         ST_F_RD:      state_in = ST_F_CHK;
         ST_F_CHK:     state_in = status.j_last ? ST_F_SELF : ST_F_RD;
         ST_F_SELF:    state_in = ST_RS_WR;
         ST_RS_WR:     state_in = status.last ? ST_DONE : ST_RS_RD;
         ST_S1_CHK:    state_in = status.root_has ? ST_S1_GO : ST_ALLOC;
         ST_S1_GO:     state_in = status.len_le24 ? ST_LS_RD : ST_S2_CHK;
         ST_S2_CHK:    state_in = status.lvl_has ? ST_S2_GO : ST_ALLOC;
         ST_S2_GO:     state_in = ST_LS_RD;
         ST_ALLOC:     state_in = status.pool_empty ? ST_DONE : ST_ALLOC_GOT;
         ST_ALLOC_GOT: state_in = ST_INIT;
         ST_INIT: begin
            if (status.last) state_in = ST_LINK;
         end
         ST_LINK:      state_in = status.tier ? ST_S2_GO : ST_S1_GO;
         ST_LS_RD:     state_in = ST_LS_CHK;
         ST_LS_CHK:    state_in = status.last ? ST_DONE : ST_LS_RD;
         ST_DONE: begin
            if (status.rsp_free) state_in = ST_IDLE;
         end
         default:      state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = OP_NONE;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd = OP_CAPTURE;
         end
         ST_DISPATCH: begin
            if (!status.is_set) begin
               cmd = OP_LOOKUP_GO;
            end else if (status.len_zero) begin
               cmd = OP_CLEAR_ALL;
            end else if (!status.root_present) begin
               cmd = OP_RINIT_GO;
            end else if (status.len_le16) begin
               cmd = OP_RS_GO;
            end else begin
               cmd = OP_S1_RD;
            end
         end
         ST_RINIT:     cmd = OP_RINIT;
         ST_LK_ROOT:   cmd = OP_LK_ROOT;
         ST_LK_L1:     cmd = OP_LK_L1;
         ST_LK_L2:     cmd = OP_LK_L2;
         ST_RS_RD:     cmd = OP_RS_RD;
         ST_RS_CHK:    cmd = OP_RS_CHK;
         ST_F_RD:      cmd = OP_F_RD;
         ST_F_CHK:     cmd = OP_F_CHK;
         ST_F_SELF:    cmd = OP_F_SELF;
         ST_RS_WR:     cmd = OP_RS_WR;
         ST_S1_CHK:    cmd = OP_S1_CHK;
         ST_S1_GO:     cmd = OP_S1_GO;
         ST_S2_CHK:    cmd = OP_S2_CHK;
         ST_S2_GO:     cmd = OP_S2_GO;
         ST_ALLOC:     cmd = OP_ALLOC;
         ST_ALLOC_GOT: cmd = OP_ALLOC_GOT;
         ST_INIT:      cmd = OP_INIT;
         ST_LINK:      cmd = OP_LINK;
         ST_LS_RD:     cmd = OP_LS_RD;
         ST_LS_CHK:    cmd = OP_LS_CHK;
         ST_DONE:      cmd = OP_EMIT;
         default:      cmd = OP_NONE;
      endcase
   end

endmodule

[rtl/rtrie_dp.sv]
// ----------------------------------------------------------------------------
// Route table datapath
// Root table, level block pool, free block stack and the registers that walk
// them under command of the controller.
// ----------------------------------------------------------------------------
`include "ipv4_multibit_trie_route_table_top_assert.svh"

module rtrie_dp
   import rtrie_pkg::*;
#(
   parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
   parameter int STATUS_WIDTH = DEF_STATUS_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_op_type              cmd,
   output dp_status_type          status,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [FIELD_WIDTH-1:0] csr_wdata
);

   localparam int SW  = STATUS_WIDTH;
   localparam int BW  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CW  = BW + 1;
   localparam int LAW = BW + LEVEL_STRIDE;
   localparam int EW  = 1 + BW + SW;
   localparam logic [CW-1:0] POOL_SIZE = CW'(NUM_BLOCKS);

   logic                    op_ff, op_in;
   logic [ADDR_WIDTH-1:0]   addr_ff, addr_in;
   logic [LEN_WIDTH-1:0]    len_ff, len_in;
   logic [SW-1:0]           val_ff, val_in;
   logic [SW-1:0]           root_st_ff, root_st_in;
   logic                    root_present_ff, root_present_in;
   logic [ROOT_STRIDE-1:0]  idx_ff, idx_in;
   logic [ROOT_STRIDE-1:0]  end_ff, end_in;
   logic [LEVEL_STRIDE-1:0] j_ff, j_in;
   logic [BW-1:0]           fblk_ff, fblk_in;
   logic [BW-1:0]           blk1_ff, blk1_in;
   logic [BW-1:0]           blk2_ff, blk2_in;
   logic [BW-1:0]           sblk_ff, sblk_in;
   logic [BW-1:0]           nblk_ff, nblk_in;
   logic [SW-1:0]           par_st_ff, par_st_in;
   logic                    tier_ff, tier_in;
   logic [CW-1:0]           scnt_ff, scnt_in;
   logic [CW-1:0]           fresh_ff, fresh_in;
   logic [SW-1:0]           res_st_ff, res_st_in;
   logic                    res_fail_ff, res_fail_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_ff, rsp_in;

   logic            root_we, root_re;
   logic [ROOT_STRIDE-1:0] root_waddr, root_raddr;
   logic [EW-1:0]   root_wdata, root_rd;
   logic            lvl_we, lvl_re;
   logic [LAW-1:0]  lvl_waddr, lvl_raddr;
   logic [EW-1:0]   lvl_wdata, lvl_rd;
   logic            stk_we, stk_re;
   logic [BW-1:0]   stk_waddr, stk_raddr, stk_wdata, stk_rd;
   logic            push;
   logic [BW-1:0]   push_blk;

   logic [63:0]     val_wide, csr_wide, res_wide;
   logic [SW-1:0]   req_val_sw, csr_val_sw;
   logic [LEN_WIDTH-1:0] req_len;
   logic [ROOT_STRIDE-1:0]  top, rfrom, rto;
   logic [LEVEL_STRIDE-1:0] b2, b3, lfrom1, lto1, lfrom2, lto2;
   logic [LEN_WIDTH-1:0]    len_sub16, len_sub24;
   logic [4:0]              ramt;
   logic            r_has, l_has;
   logic [BW-1:0]   r_child, l_child;
   logic [SW-1:0]   r_st, l_st;
   logic            pool_empty, rsp_free;
   logic [CW-1:0]   scnt_m1;

   function automatic logic [LEVEL_STRIDE-1:0] lvl_lo(input logic [LEVEL_STRIDE-1:0] b,
                                                      input logic [3:0] rem);
      return b & (8'hFF << (4'd8 - rem));
   endfunction

   function automatic logic [LEVEL_STRIDE-1:0] lvl_hi(input logic [LEVEL_STRIDE-1:0] lo,
                                                      input logic [3:0] rem);
      return lo | (8'hFF >> rem);
   endfunction

   rtrie_ram #(.WIDTH(EW), .DEPTH(ROOT_SIZE), .ADDR_W(ROOT_STRIDE)) u_root_ram (
      .clock(clock), .we(root_we), .waddr(root_waddr), .wdata(root_wdata),
      .re(root_re), .raddr(root_raddr), .rdata(root_rd)
   );

   rtrie_ram #(.WIDTH(EW), .DEPTH(NUM_BLOCKS * LEVEL_SIZE), .ADDR_W(LAW)) u_level_ram (
      .clock(clock), .we(lvl_we), .waddr(lvl_waddr), .wdata(lvl_wdata),
      .re(lvl_re), .raddr(lvl_raddr), .rdata(lvl_rd)
   );

   rtrie_ram #(.WIDTH(BW), .DEPTH(NUM_BLOCKS), .ADDR_W(BW)) u_stack_ram (
      .clock(clock), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
      .re(stk_re), .raddr(stk_raddr), .rdata(stk_rd)
   );

   assign val_wide   = {32'b0, req_data.status_value};
   assign req_val_sw = val_wide[SW-1:0];
   assign csr_wide   = {32'b0, csr_wdata};
   assign csr_val_sw = csr_wide[SW-1:0];
   assign res_wide   = 64'(res_st_ff);
   assign req_len    = (req_data.prefix_length > LEN_WIDTH'(MAX_PREFIX)) ?
                       LEN_WIDTH'(MAX_PREFIX) : req_data.prefix_length;

   assign top       = addr_ff[31:16];
   assign b2        = addr_ff[15:8];
   assign b3        = addr_ff[7:0];
   assign ramt      = len_ff[4:0];
   assign rfrom     = top & (16'hFFFF << (5'd16 - ramt));
   assign rto       = rfrom | (16'hFFFF >> ramt);
   assign len_sub16 = len_ff - 6'd16;
   assign len_sub24 = len_ff - 6'd24;
   assign lfrom1    = lvl_lo(b2, len_sub16[3:0]);
   assign lto1      = lvl_hi(lfrom1, len_sub16[3:0]);
   assign lfrom2    = lvl_lo(b3, len_sub24[3:0]);
   assign lto2      = lvl_hi(lfrom2, len_sub24[3:0]);

   assign r_has   = root_rd[EW-1];
   assign r_child = root_rd[SW +: BW];
   assign r_st    = root_rd[SW-1:0];
   assign l_has   = lvl_rd[EW-1];
   assign l_child = lvl_rd[SW +: BW];
   assign l_st    = lvl_rd[SW-1:0];

   assign pool_empty = (scnt_ff == '0) && (fresh_ff == POOL_SIZE);
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign scnt_m1    = scnt_ff - CW'(1);

   always_comb begin
      op_in           = op_ff;
      addr_in         = addr_ff;
      len_in          = len_ff;
      val_in          = val_ff;
      root_st_in      = root_st_ff;
      root_present_in = root_present_ff;
      idx_in          = idx_ff;
      end_in          = end_ff;
      j_in            = j_ff;
      fblk_in         = fblk_ff;
      blk1_in         = blk1_ff;
      blk2_in         = blk2_ff;
      sblk_in         = sblk_ff;
      nblk_in         = nblk_ff;
      par_st_in       = par_st_ff;
      tier_in         = tier_ff;
      scnt_in         = scnt_ff;
      fresh_in        = fresh_ff;
      res_st_in       = res_st_ff;
      res_fail_in     = res_fail_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_in          = rsp_ff;
      root_we    = 1'b0;
      root_waddr = idx_ff;
      root_wdata = '0;
      root_re    = 1'b0;
      root_raddr = top;
      lvl_we     = 1'b0;
      lvl_waddr  = {sblk_ff, idx_ff[7:0]};
      lvl_wdata  = '0;
      lvl_re     = 1'b0;
      lvl_raddr  = {sblk_ff, idx_ff[7:0]};
      stk_we     = 1'b0;
      stk_waddr  = scnt_ff[BW-1:0];
      stk_wdata  = '0;
      stk_re     = 1'b0;
      stk_raddr  = scnt_m1[BW-1:0];
      push       = 1'b0;
      push_blk   = '0;

      if (rsp_valid_ff && rsp_ready) rsp_valid_in = 1'b0;

      case (cmd)
         OP_CAPTURE: begin
            op_in       = req_data.operation;
            addr_in     = req_data.address;
            len_in      = req_len;
            val_in      = req_val_sw;
            res_st_in   = '0;
            res_fail_in = 1'b0;
         end
         OP_LOOKUP_GO: begin
            root_re   = 1'b1;
            res_st_in = root_st_ff;
         end
         OP_CLEAR_ALL: begin
            fresh_in        = '0;
            scnt_in         = '0;
            root_present_in = 1'b0;
            root_st_in      = val_ff;
         end
         OP_RINIT_GO: begin
            idx_in = '0;
            end_in = 16'hFFFF;
         end
         OP_RINIT: begin
            root_we    = 1'b1;
            root_wdata = {1'b0, {BW{1'b0}}, root_st_ff};
            idx_in     = idx_ff + 16'd1;
            if (idx_ff == end_ff) root_present_in = 1'b1;
         end
         OP_RS_GO: begin
            idx_in = rfrom;
            end_in = rto;
         end
         OP_S1_RD: begin
            root_re = 1'b1;
         end
         OP_LK_ROOT: begin
            res_st_in = r_st;
            lvl_re    = 1'b1;
            lvl_raddr = {r_child, b2};
         end
         OP_LK_L1: begin
            res_st_in = l_st;
            lvl_re    = 1'b1;
            lvl_raddr = {l_child, b3};
         end
         OP_LK_L2: begin
            res_st_in = l_st;
         end
         OP_RS_RD: begin
            root_re    = 1'b1;
            root_raddr = idx_ff;
         end
         OP_RS_CHK: begin
            if (r_has) begin
               fblk_in = r_child;
               j_in    = '0;
            end
         end
         OP_RS_WR: begin
            root_we    = 1'b1;
            root_wdata = {1'b0, {BW{1'b0}}, val_ff};
            idx_in     = idx_ff + 16'd1;
         end
         OP_F_RD: begin
            lvl_re    = 1'b1;
            lvl_raddr = {fblk_ff, j_ff};
         end
         OP_F_CHK: begin
            push     = l_has;
            push_blk = l_child;
            j_in     = j_ff + 8'd1;
         end
         OP_F_SELF: begin
            push     = 1'b1;
            push_blk = fblk_ff;
         end
         OP_S1_CHK: begin
            par_st_in = r_st;
            blk1_in   = r_child;
            tier_in   = 1'b0;
         end
         OP_S1_GO: begin
            sblk_in   = blk1_ff;
            idx_in    = {8'b0, lfrom1};
            end_in    = {8'b0, lto1};
            lvl_re    = 1'b1;
            lvl_raddr = {blk1_ff, b2};
         end
         OP_S2_CHK: begin
            par_st_in = l_st;
            blk2_in   = l_child;
            tier_in   = 1'b1;
         end
         OP_S2_GO: begin
            sblk_in = blk2_ff;
            idx_in  = {8'b0, lfrom2};
            end_in  = {8'b0, lto2};
         end
         OP_ALLOC: begin
            stk_re = 1'b1;
            if (pool_empty) res_fail_in = 1'b1;
         end
         OP_ALLOC_GOT: begin
            if (scnt_ff != '0) begin
               nblk_in = stk_rd;
               scnt_in = scnt_m1;
            end else begin
               nblk_in  = fresh_ff[BW-1:0];
               fresh_in = fresh_ff + CW'(1);
            end
            idx_in = '0;
            end_in = 16'd255;
         end
         OP_INIT: begin
            lvl_we    = 1'b1;
            lvl_waddr = {nblk_ff, idx_ff[7:0]};
            lvl_wdata = {1'b0, {BW{1'b0}}, par_st_ff};
            idx_in    = idx_ff + 16'd1;
         end
         OP_LINK: begin
            if (!tier_ff) begin
               root_we    = 1'b1;
               root_waddr = top;
               root_wdata = {1'b1, nblk_ff, par_st_ff};
               blk1_in    = nblk_ff;
            end else begin
               lvl_we    = 1'b1;
               lvl_waddr = {blk1_ff, b2};
               lvl_wdata = {1'b1, nblk_ff, par_st_ff};
               blk2_in   = nblk_ff;
            end
         end
         OP_LS_RD: begin
            lvl_re = 1'b1;
         end
         OP_LS_CHK: begin
            push      = l_has;
            push_blk  = l_child;
            lvl_we    = 1'b1;
            lvl_wdata = {1'b0, {BW{1'b0}}, val_ff};
            idx_in    = idx_ff + 16'd1;
         end
         OP_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = res_wide[31:0];
               rsp_in.failed = res_fail_ff;
            end
         end
         default: begin
         end
      endcase

      if (push && (scnt_ff < POOL_SIZE)) begin
         stk_we    = 1'b1;
         stk_wdata = push_blk;
         scnt_in   = scnt_ff + CW'(1);
      end

      if (csr_we) root_st_in = csr_val_sw;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_st_ff      <= '0;
         root_present_ff <= 1'b0;
         scnt_ff         <= '0;
         fresh_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         root_st_ff      <= root_st_in;
         root_present_ff <= root_present_in;
         scnt_ff         <= scnt_in;
         fresh_ff        <= fresh_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      len_ff      <= len_in;
      val_ff      <= val_in;
      idx_ff      <= idx_in;
      end_ff      <= end_in;
      j_ff        <= j_in;
      fblk_ff     <= fblk_in;
      blk1_ff     <= blk1_in;
      blk2_ff     <= blk2_in;
      sblk_ff     <= sblk_in;
      nblk_ff     <= nblk_in;
      par_st_ff   <= par_st_in;
      tier_ff     <= tier_in;
      res_st_ff   <= res_st_in;
      res_fail_ff <= res_fail_in;
      rsp_ff      <= rsp_in;
   end

   assign status.is_set       = (op_ff == OPERATION_SET);
   assign status.len_zero     = (len_ff == '0);
   assign status.len_le16     = (len_ff <= 6'd16);
   assign status.len_le24     = (len_ff <= 6'd24);
   assign status.root_present = root_present_ff;
   assign status.root_has     = r_has;
   assign status.lvl_has      = l_has;
   assign status.last         = (idx_ff == end_ff);
   assign status.j_last       = (j_ff == 8'hFF);
   assign status.pool_empty   = pool_empty;
   assign status.tier         = tier_ff;
   assign status.rsp_free     = rsp_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `RTRIE_ASSERT_NOW(a_pool_balance, clock, reset, 1'b1, scnt_ff <= fresh_ff, "free stack exceeds issued blocks")
   `RTRIE_ASSERT_NEXT(a_clear_all, clock, reset, cmd == OP_CLEAR_ALL, !root_present_ff && scnt_ff == '0, "clear did not drop the root table")
   `RTRIE_ASSERT_NEXT(a_alloc_fail, clock, reset, cmd == OP_ALLOC && pool_empty, res_fail_ff, "empty pool not flagged")

endmodule

[rtl/ipv4_multibit_trie_route_table_top.sv]
// ----------------------------------------------------------------------------
// IPv4 multibit trie route table
// A 16-8-8 trie with longest-prefix match lookups and prefix range writes.
// ----------------------------------------------------------------------------
// Requests arrive on the req_ valid/ready channel, one beat per lookup or
// set; each gives exactly one beat on the rsp_ channel. csr_we loads the
// default status, which answers lookups while no root table exists.
// A lookup makes up to three dependent registered RAM reads (root, then two
// level blocks) before its response beat. The first set of nonzero length
// after reset or after a length-zero set first fills the 65536-entry root
// table, one entry a cycle. A set then walks its range at its level entry
// by entry, releasing the level blocks below entries that it overwrites and
// creating the blocks that it lacks. Requests are handled one at a time; the
// next request is taken as soon as the controller is back in idle, even
// while the previous response waits in its output register. A stalled
// receiver holds the response beat and blocks only the following completion.
// Reset empties the route table, frees all blocks and clears the default
// status to zero.
// ----------------------------------------------------------------------------
module ipv4_multibit_trie_route_table_top
   import rtrie_pkg::*;
#(
   parameter int NUM_BLOCKS   = DEF_NUM_BLOCKS,
   parameter int STATUS_WIDTH = DEF_STATUS_WIDTH
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rsp_type                rsp_data,
   input  logic                   csr_we,
   input  logic [FIELD_WIDTH-1:0] csr_wdata
);

   dp_op_type     cmd;
   dp_status_type dp_status;

   rtrie_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (dp_status),
      .cmd       (cmd)
   );

   rtrie_dp #(
      .NUM_BLOCKS   (NUM_BLOCKS),
      .STATUS_WIDTH (STATUS_WIDTH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (dp_status),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

endmodule

[tb/tb_ipv4_multibit_trie_route_table_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Route table top-level testbench
// Drives lookups and prefix sets through the request channel and checks every
// response beat against a behavioral 16-8-8 trie kept in the testbench. The
// sender works in random bursts, the receiver stalls on its own pattern, and
// the default status register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb_ipv4_multibit_trie_route_table_top;
   import rtrie_pkg::*;

   localparam int NB = DEF_NUM_BLOCKS;

   logic            clock;
   logic            reset;
   logic            req_valid;
   logic            req_ready;
   req_type         req_data;
   logic            rsp_valid;
   logic            rsp_ready;
   rsp_type         rsp_data;
   logic            csr_we;
   logic [31:0]     csr_wdata;

   ipv4_multibit_trie_route_table_top u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Trie mirror.
   logic [31:0] root_status;
   bit          root_present;
   logic [31:0] root_st [ROOT_SIZE];
   bit          root_has [ROOT_SIZE];
   int          root_ch [ROOT_SIZE];
   logic [31:0] lvl_st [NB*LEVEL_SIZE];
   bit          lvl_has [NB*LEVEL_SIZE];
   int          lvl_ch [NB*LEVEL_SIZE];
   int          free_list [NB];
   int          free_cnt;

   rsp_type     expected_rsp_q [$];
   int          error_count;
   int          burst_left;
   int          fail_seen;
   int          zero_sets_left;
   logic [15:0] top_pool [24];
   logic [7:0]  mid_pool [6];

   function automatic void release_block(int blk);
      for (int i = 0; i < LEVEL_SIZE; i++) begin
         if (lvl_has[blk*LEVEL_SIZE+i]) begin
            lvl_has[blk*LEVEL_SIZE+i] = 0;
            release_block(lvl_ch[blk*LEVEL_SIZE+i]);
         end
      end
      if (free_cnt < NB) begin
         free_list[free_cnt] = blk;
         free_cnt++;
      end
   endfunction

   function automatic bit grab_block(logic [31:0] st, output int blk);
      if (free_cnt == 0) return 0;
      free_cnt--;
      blk = free_list[free_cnt];
      for (int i = 0; i < LEVEL_SIZE; i++) begin
         lvl_st[blk*LEVEL_SIZE+i] = st;
         lvl_has[blk*LEVEL_SIZE+i] = 0;
         lvl_ch[blk*LEVEL_SIZE+i] = 0;
      end
      return 1;
   endfunction

   function automatic void clear_root(int r);
      if (root_has[r]) begin
         root_has[r] = 0;
         release_block(root_ch[r]);
      end
   endfunction

   function automatic void clear_lvl(int e);
      if (lvl_has[e]) begin
         lvl_has[e] = 0;
         release_block(lvl_ch[e]);
      end
   endfunction

   function automatic void fill_block(int blk, int byte_idx, int rem, logic [31:0] st);
      int lo;
      int hi;
      lo = byte_idx & ((8'hFF << (8 - rem)) & 8'hFF);
      hi = lo | (8'hFF >> rem);
      for (int i = lo; i <= hi; i++) begin
         clear_lvl(blk*LEVEL_SIZE+i);
         lvl_st[blk*LEVEL_SIZE+i] = st;
      end
   endfunction

   function automatic bit apply_route(logic [31:0] addr, int len, logic [31:0] st);
      int top;
      int b2;
      int b3;
      int rem;
      int blk1;
      int blk2;
      int e1;
      int lo;
      int hi;
      top = addr[31:16];
      b2 = addr[15:8];
      b3 = addr[7:0];
      if (len == 0) begin
         if (root_present) begin
            for (int i = 0; i < ROOT_SIZE; i++) clear_root(i);
            root_present = 0;
         end
         root_status = st;
         return 1;
      end
      if (!root_present) begin
         for (int i = 0; i < ROOT_SIZE; i++) begin
            root_st[i] = root_status;
            root_has[i] = 0;
            root_ch[i] = 0;
         end
         root_present = 1;
      end
      if (len < ROOT_STRIDE) begin
         lo = top & ((16'hFFFF << (ROOT_STRIDE - len)) & 16'hFFFF);
         hi = lo | (16'hFFFF >> len);
         for (int i = lo; i <= hi; i++) begin
            clear_root(i);
            root_st[i] = st;
         end
         return 1;
      end
      rem = len - ROOT_STRIDE;
      if (rem == 0) begin
         clear_root(top);
         root_st[top] = st;
         return 1;
      end
      if (!root_has[top]) begin
         if (!grab_block(root_st[top], blk1)) return 0;
         root_has[top] = 1;
         root_ch[top] = blk1;
      end
      blk1 = root_ch[top];
      if (rem < LEVEL_STRIDE) begin
         fill_block(blk1, b2, rem, st);
         return 1;
      end
      e1 = blk1*LEVEL_SIZE + b2;
      if (rem == LEVEL_STRIDE) begin
         clear_lvl(e1);
         lvl_st[e1] = st;
         return 1;
      end
      if (!lvl_has[e1]) begin
         if (!grab_block(lvl_st[e1], blk2)) return 0;
         lvl_has[e1] = 1;
         lvl_ch[e1] = blk2;
      end
      blk2 = lvl_ch[e1];
      rem -= LEVEL_STRIDE;
      if (rem < LEVEL_STRIDE) begin
         fill_block(blk2, b3, rem, st);
      end else begin
         clear_lvl(blk2*LEVEL_SIZE+b3);
         lvl_st[blk2*LEVEL_SIZE+b3] = st;
      end
      return 1;
   endfunction

   function automatic logic [31:0] route_status_of(logic [31:0] addr);
      int r;
      int e;
      if (!root_present) return root_status;
      r = addr[31:16];
      if (!root_has[r]) return root_st[r];
      e = root_ch[r]*LEVEL_SIZE + addr[15:8];
      if (!lvl_has[e]) return lvl_st[e];
      e = lvl_ch[e]*LEVEL_SIZE + addr[7:0];
      return lvl_st[e];
   endfunction

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #40_000_000;
      $display("== FAIL ==");
      $finish;
   end

   // Receiver stall pattern: alternating calm and choppy stretches.
   initial begin
      int span;
      bit choppy;
      rsp_ready = 1'b1;
      choppy = 0;
      forever begin
         span = $urandom_range(16, 400);
         choppy = ~choppy;
         repeat (span) begin
            @(negedge clock);
            rsp_ready = choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_rsp_q.size() == 0) begin
            $display("%0t: unexpected response beat status=%h failed=%b", $time,
                     rsp_data.status, rsp_data.failed);
            error_count++;
         end else begin
            want = expected_rsp_q.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch expected=%h actual=%h", $time,
                        want.status, rsp_data.status);
               error_count++;
            end
            if (rsp_data.failed !== want.failed) begin
               $display("%0t: failed mismatch expected=%b actual=%b", $time,
                        want.failed, rsp_data.failed);
               error_count++;
            end
         end
      end
   end

   task automatic send_beat(logic op, logic [31:0] addr, logic [5:0] len,
                            logic [31:0] val);
      rsp_type want;
      int eff_len;
      @(negedge clock);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      burst_left--;
      req_valid = 1'b1;
      req_data.operation = op;
      req_data.address = addr;
      req_data.prefix_length = len;
      req_data.status_value = val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      eff_len = (len > MAX_PREFIX) ? MAX_PREFIX : len;
      if (op == OPERATION_LOOKUP) begin
         want.status = route_status_of(addr);
         want.failed = 1'b0;
      end else begin
         want.status = '0;
         want.failed = !apply_route(addr, eff_len, val);
         if (want.failed) fail_seen++;
      end
      expected_rsp_q.push_back(want);
   endtask

   task automatic drain;
      @(negedge clock);
      req_valid = 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_default(logic [31:0] v);
      @(negedge clock);
      csr_we = 1'b1;
      csr_wdata = v;
      @(negedge clock);
      csr_we = 1'b0;
      root_status = v;
   endtask

   task automatic test_default_status;
      write_default(32'hFFFF_FFFF);
      send_beat(OPERATION_LOOKUP, 32'h0000_0000, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'hFFFF_FFFF, 6'd63, 32'hFFFF_FFFF);
      drain();
      write_default(32'h0000_0000);
      send_beat(OPERATION_LOOKUP, 32'h1234_5678, 6'd0, 32'h0);
      drain();
   endtask

   task automatic test_zero_length_set;
      send_beat(OPERATION_SET, 32'hDEAD_BEEF, 6'd0, 32'hA5A5_0001);
      send_beat(OPERATION_LOOKUP, 32'h0102_0304, 6'd0, 32'h0);
      drain();
      write_default(32'h5A5A_5A5A);
      send_beat(OPERATION_LOOKUP, 32'hFFFF_0000, 6'd0, 32'h0);
      drain();
   endtask

   task automatic test_prefix_levels;
      send_beat(OPERATION_SET, 32'h8000_0000, 6'd1, 32'h0000_0011);
      send_beat(OPERATION_LOOKUP, 32'h7FFF_FFFF, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h8000_0000, 6'd0, 32'h0);
      send_beat(OPERATION_SET, 32'h0A0B_0000, 6'd16, 32'h0000_0016);
      send_beat(OPERATION_SET, 32'h0A0B_C000, 6'd20, 32'h0000_0020);
      send_beat(OPERATION_SET, 32'h0A0B_CC00, 6'd24, 32'h0000_0024);
      send_beat(OPERATION_SET, 32'h0A0B_CCF0, 6'd28, 32'h0000_0028);
      send_beat(OPERATION_SET, 32'h0A0B_CCF5, 6'd32, 32'h0000_0032);
      send_beat(OPERATION_SET, 32'h0A0B_CC01, 6'd40, 32'hFFFF_FFFF);
      send_beat(OPERATION_SET, 32'h0A0B_CC02, 6'd63, 32'h0000_0063);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CCF5, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CCF4, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CC01, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CC02, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CC80, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_C500, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_0000, 6'd0, 32'h0);
      send_beat(OPERATION_SET, 32'h0A0C_CC00, 6'd12, 32'h0000_0012);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CCF5, 6'd0, 32'h0);
      send_beat(OPERATION_SET, 32'h0000_0000, 6'd0, 32'h0000_0000);
      send_beat(OPERATION_LOOKUP, 32'h0A0B_CCF5, 6'd0, 32'h0);
      drain();
   endtask

   task automatic test_random_routes(int count);
      logic [31:0] addr;
      logic [31:0] val;
      logic [5:0]  len;
      int          pick;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(0, 99);
         addr = {top_pool[$urandom_range(0, 23)], mid_pool[$urandom_range(0, 5)],
                 8'($urandom)};
         if ($urandom_range(0, 4) == 0) addr = $urandom;
         case ($urandom_range(0, 7))
            0:       val = 32'h0;
            1:       val = 32'hFFFF_FFFF;
            default: val = $urandom;
         endcase
         if (pick < 50) begin
            send_beat(OPERATION_LOOKUP, addr, 6'($urandom), $urandom);
         end else begin
            if (pick == 50 && zero_sets_left > 0) begin
               zero_sets_left--;
               len = 6'd0;
            end else if (pick < 53) begin
               len = 6'($urandom_range(9, 15));
            end else if (pick < 56) begin
               len = 6'($urandom_range(33, 63));
            end else begin
               len = 6'($urandom_range(16, 32));
            end
            send_beat(OPERATION_SET, addr, len, val);
         end
      end
      drain();
   endtask

   task automatic test_pool_exhaustion;
      int i;
      i = 0;
      while (fail_seen < 8 && i < 1100) begin
         send_beat(OPERATION_SET, {16'(16'h4000 + i), 8'h11, 8'h22}, 6'd32, $urandom);
         if (i % 4 == 0)
            send_beat(OPERATION_LOOKUP, {16'(16'h4000 + i), 8'h11, 8'h22}, 6'd0, 32'h0);
         i++;
      end
      send_beat(OPERATION_LOOKUP, {16'(16'h4000 + i - 1), 8'h11, 8'h22}, 6'd0, 32'h0);
      send_beat(OPERATION_LOOKUP, 32'h4000_1122, 6'd0, 32'h0);
      drain();
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_we = 1'b0;
      csr_wdata = '0;
      error_count = 0;
      burst_left = 0;
      fail_seen = 0;
      zero_sets_left = 2;
      root_status = '0;
      root_present = 0;
      free_cnt = NB;
      for (int i = 0; i < NB; i++) free_list[i] = i;
      for (int i = 0; i < 24; i++) top_pool[i] = 16'($urandom);
      for (int i = 0; i < 6; i++) mid_pool[i] = 8'($urandom);
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_default_status();
      test_zero_length_set();
      test_prefix_levels();
      write_default($urandom);
      test_random_routes(320);
      write_default(32'hFFFF_FFFF);
      test_random_routes(320);
      write_default(32'h0000_0000);
      test_random_routes(320);
      write_default($urandom);
      test_random_routes(320);
      test_pool_exhaustion();

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
